[sv/c2d_pkg.sv]
// ---------------------------------------------------------------------------
// c2d_pkg: shared types and constants of the convolution engine
// Opcodes, register indexes, FSM states and the structs passed between the
// front end, the compute back end and the top level.
// ---------------------------------------------------------------------------
package c2d_pkg;

    localparam int DEF_MAX_IN_WIDTH  = 32;
    localparam int DEF_MAX_IN_HEIGHT = 32;
    localparam int DEF_MAX_IN_DEPTH  = 16;
    localparam int DEF_MAX_SIDE      = 7;
    localparam int DEF_MAX_FILTERS   = 16;

    // Depth of the command queue between front and back end
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_LOAD_ACT  = 2'd0,
        OP_LOAD_WGT  = 2'd1,
        OP_LOAD_BIAS = 2'd2,
        OP_COMPUTE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_IN_WIDTH    = 3'd0,
        CFG_IN_HEIGHT   = 3'd1,
        CFG_IN_DEPTH    = 3'd2,
        CFG_KERNEL_SIDE = 3'd3,
        CFG_STEP        = 3'd4,
        CFG_PADDING     = 3'd5,
        CFG_NUM_FILTERS = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } bk_state_t;

    // Effective (clamped) layer geometry
    typedef struct packed {
        logic [5:0] w;
        logic [5:0] h;
        logic [4:0] d;
        logic [2:0] s;
        logic [2:0] st;
        logic [2:0] pad;
        logic [4:0] nf;
    } cfg_t;

    // Classified compute request
    typedef struct packed {
        logic              bad;
        logic [3:0]        filter;
        logic signed [9:0] x0;
        logic signed [9:0] y0;
    } cmd_t;

    // Store write from a load item
    typedef struct packed {
        logic        act_we;
        logic        wgt_we;
        logic        bias_we;
        logic [13:0] addr;
        logic [31:0] data;
    } wr_t;

    // Back end status seen by the front end
    typedef struct packed {
        logic take;
        logic busy;
    } bk_stat_t;

    // Saturate a 32-bit value to signed 16 bits
    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [15:0] r;
        if (v > 32'sd32767)
            r = 16'h7FFF;
        else if (v < -32'sd32768)
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

[sv/c2d_ram.sv]
// ---------------------------------------------------------------------------
// c2d_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/c2d_front.sv]
// ---------------------------------------------------------------------------
// c2d_front: item intake and classification
// Holds load items until the back end is quiet, then writes the stores;
// checks compute requests against output size and filter count, queues them.
// ---------------------------------------------------------------------------
module c2d_front import c2d_pkg::*; #(
    parameter int ACT_DEPTH   = 16384,
    parameter int WGT_DEPTH   = 12544,
    parameter int MAX_FILTERS = DEF_MAX_FILTERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [13:0] addr,
    input  logic [31:0] data,
    input  logic [4:0]  out_col,
    input  logic [4:0]  out_row,
    input  logic [3:0]  filter_sel,
    input  cfg_t        cfg,
    input  bk_stat_t    bk,
    output cmd_t        cmd,
    output logic        cmd_valid,
    output wr_t         wr
);

    cmd_t        q_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QAW:0]   count_reg;

    logic        ld_valid_reg;
    op_t         ld_op_reg;
    logic [13:0] ld_addr_reg;
    logic [31:0] ld_data_reg;

    logic        accept, is_load, ld_fire, q_push, q_pop;
    logic [7:0]  col_pos, row_pos;
    logic [9:0]  col_end, row_end, span_w, span_h;
    cmd_t        new_cmd;

    assign full    = (count_reg == (QAW+1)'(QDEPTH)) || ld_valid_reg;
    assign accept  = push && !full;
    assign is_load = (op_t'(opcode) != OP_COMPUTE);
    assign q_push  = accept && !is_load;
    assign q_pop   = bk.take;
    assign ld_fire = ld_valid_reg && (count_reg == '0) && !bk.busy;

    // Classify a compute request: window must fit padded plane, filter below nf
    always_comb
    begin
        col_pos = 8'(out_col * cfg.st);
        row_pos = 8'(out_row * cfg.st);
        col_end = 10'(col_pos) + 10'(cfg.s);
        row_end = 10'(row_pos) + 10'(cfg.s);
        span_w  = 10'(cfg.w) + 10'({cfg.pad, 1'b0});
        span_h  = 10'(cfg.h) + 10'({cfg.pad, 1'b0});
        new_cmd.bad    = (col_end > span_w) || (row_end > span_h)
                         || (5'(filter_sel) >= cfg.nf);
        new_cmd.filter = filter_sel;
        new_cmd.x0     = $signed(10'(col_pos)) - $signed(10'(cfg.pad));
        new_cmd.y0     = $signed(10'(row_pos)) - $signed(10'(cfg.pad));
    end

    // Command queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (q_push)
                wptr_reg <= wptr_reg + 1'b1;
            if (q_pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (q_push && !q_pop)
                count_reg <= count_reg + 1'b1;
            else if (!q_push && q_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_reg[wptr_reg] <= new_cmd;
    end

    assign cmd       = q_reg[rptr_reg];
    assign cmd_valid = (count_reg != '0);

    // Hold a load until earlier computes are done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_valid_reg <= 1'b0;
        else if (accept && is_load)
            ld_valid_reg <= 1'b1;
        else if (ld_fire)
            ld_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_load)
        begin
            ld_op_reg   <= op_t'(opcode);
            ld_addr_reg <= addr;
            if (op_t'(opcode) == OP_LOAD_BIAS)
                ld_data_reg <= data;
            else
                ld_data_reg <= 32'($signed(sat16($signed(data))));
        end
    end

    // Drive the store writes, dropping addresses beyond each store
    always_comb
    begin
        wr.addr    = ld_addr_reg;
        wr.data    = ld_data_reg;
        wr.act_we  = ld_fire && (ld_op_reg == OP_LOAD_ACT)
                     && (32'(ld_addr_reg) < 32'(ACT_DEPTH));
        wr.wgt_we  = ld_fire && (ld_op_reg == OP_LOAD_WGT)
                     && (32'(ld_addr_reg) < 32'(WGT_DEPTH));
        wr.bias_we = ld_fire && (ld_op_reg == OP_LOAD_BIAS)
                     && (32'(ld_addr_reg) < 32'(MAX_FILTERS));
    end

endmodule

[sv/c2d_back.sv]
// ---------------------------------------------------------------------------
// c2d_back: multiply-accumulate sequencer
// Walks each window tap over all channels, reads both stores, accumulates
// the products, adds the bias and saturates into the result register.
// ---------------------------------------------------------------------------
module c2d_back import c2d_pkg::*; #(
    parameter int ACT_DEPTH   = 16384,
    parameter int WGT_DEPTH   = 12544,
    parameter int MAX_FILTERS = DEF_MAX_FILTERS,
    localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1,
    localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1,
    localparam int BAW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  cmd_t           cmd,
    input  logic           cmd_valid,
    output bk_stat_t       bk,
    output logic [AAW-1:0] act_raddr,
    input  logic [15:0]    act_rdata,
    output logic [WAW-1:0] wgt_raddr,
    input  logic [15:0]    wgt_rdata,
    output logic [BAW-1:0] bias_raddr,
    input  logic [31:0]    bias_rdata,
    input  logic           pop,
    output logic           empty,
    output logic [31:0]    result,
    output logic           saturated,
    output logic           bad_request
);

    bk_state_t state_reg, state_next;
    cmd_t      cur_reg;

    logic [5:0]        ss_reg;
    logic [8:0]        fd_reg;
    logic [AAW-1:0]    ybase_reg, plane_reg, pix_reg, aoff_reg;
    logic [WAW-1:0]    fdss_reg, woff_reg;
    logic [5:0]        wtap_reg;
    logic [4:0]        z_reg;
    logic [2:0]        fx_reg, fy_reg;
    logic signed [9:0] ix_reg, iy_reg;
    logic [31:0]       bias_reg;

    logic               v1_reg, v2_reg;
    logic signed [31:0] prod_reg;
    logic signed [47:0] acc_reg;

    logic        out_valid_reg;
    logic [31:0] result_reg;
    logic        sat_reg, bad_reg;

    logic               take, issue, out_load, out_free;
    logic               z_last, fx_last, fy_last, in_range;
    logic signed [16:0] ybase_prod;
    logic signed [47:0] total;
    logic               total_sat;

    assign out_free = !out_valid_reg || pop;
    assign z_last   = (z_reg == cfg.d - 5'd1);
    assign fx_last  = (fx_reg == cfg.s - 3'd1);
    assign fy_last  = (fy_reg == cfg.s - 3'd1);
    assign in_range = !iy_reg[9] && (iy_reg[8:0] < 9'(cfg.h))
                      && !ix_reg[9] && (ix_reg[8:0] < 9'(cfg.w));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = cmd.bad ? ST_FINISH : ST_SETUP;
            ST_SETUP:  state_next = ST_PREP;
            ST_PREP:   state_next = ST_RUN;
            ST_RUN:
                if (z_last && fx_last && fy_last)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!v1_reg && !v2_reg)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        take     = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   take     = cmd_valid;
            ST_RUN:    issue    = 1'b1;
            ST_FINISH: out_load = out_free;
            default:   ;
        endcase
    end

    assign bk.take = take;
    assign bk.busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign ybase_prod = cur_reg.y0 * $signed({1'b0, cfg.w});

    // Setup products and the tap walk
    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= cmd;
        if (state_reg == ST_SETUP)
        begin
            ss_reg    <= 6'(cfg.s * cfg.s);
            fd_reg    <= 9'(cur_reg.filter * cfg.d);
            ybase_reg <= AAW'(ybase_prod);
            plane_reg <= AAW'(cfg.h * cfg.w);
        end
        if (state_reg == ST_PREP)
        begin
            fdss_reg <= WAW'(fd_reg * ss_reg);
            pix_reg  <= ybase_reg + AAW'(cur_reg.x0);
            bias_reg <= bias_rdata;
            aoff_reg <= '0;
            woff_reg <= '0;
            wtap_reg <= '0;
            z_reg    <= '0;
            fx_reg   <= '0;
            fy_reg   <= '0;
            ix_reg   <= cur_reg.x0;
            iy_reg   <= cur_reg.y0;
        end
        if (issue)
        begin
            if (z_last)
            begin
                // advance to the next tap of the window
                z_reg    <= '0;
                aoff_reg <= '0;
                woff_reg <= '0;
                wtap_reg <= wtap_reg + 6'd1;
                if (fx_last)
                begin
                    fx_reg  <= '0;
                    fy_reg  <= fy_reg + 3'd1;
                    ix_reg  <= cur_reg.x0;
                    iy_reg  <= iy_reg + 10'sd1;
                    pix_reg <= pix_reg + AAW'(cfg.w) - AAW'(cfg.s) + AAW'(1);
                end
                else
                begin
                    fx_reg  <= fx_reg + 3'd1;
                    ix_reg  <= ix_reg + 10'sd1;
                    pix_reg <= pix_reg + AAW'(1);
                end
            end
            else
            begin
                z_reg    <= z_reg + 5'd1;
                aoff_reg <= aoff_reg + plane_reg;
                woff_reg <= woff_reg + WAW'(ss_reg);
            end
        end
    end

    assign act_raddr  = aoff_reg + pix_reg;
    assign wgt_raddr  = fdss_reg + woff_reg + WAW'(wtap_reg);
    assign bias_raddr = BAW'(cur_reg.filter);

    // Multiply-accumulate pipeline: read, multiply, add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue && in_range;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(act_rdata) * $signed(wgt_rdata);
        if (state_reg == ST_PREP)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + 48'(prod_reg);
    end

    // Add bias and clamp to 32 bits
    always_comb
    begin
        total     = acc_reg + 48'($signed(bias_reg));
        total_sat = (total[47:31] != {17{total[31]}});
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            bad_reg <= cur_reg.bad;
            if (cur_reg.bad)
            begin
                result_reg <= '0;
                sat_reg    <= 1'b0;
            end
            else
            begin
                sat_reg <= total_sat;
                if (!total_sat)
                    result_reg <= total[31:0];
                else if (total[47])
                    result_reg <= 32'h8000_0000;
                else
                    result_reg <= 32'h7FFF_FFFF;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign result      = result_reg;
    assign saturated   = sat_reg;
    assign bad_request = bad_reg;

endmodule

[sv/conv2d_forward_engine.sv]
// ---------------------------------------------------------------------------
// conv2d_forward_engine: 2D convolution, forward pass
// Load items fill the activation, weight and bias stores; a compute item
// returns one output value of a strided, zero-padded convolution.
// ---------------------------------------------------------------------------
// A load item writes its store once every earlier compute item has finished.
// A compute item runs setup, a walk of kernel_side*kernel_side*in_depth
// products, drain and bias add on the single multiply-accumulate unit,
// reading one activation and one weight per cycle; a request outside the
// output size or past num_filters skips the walk and returns zero, flagged
// bad. Taps in the padding are walked but add nothing. Results wait in a
// one-entry output register while the next item is taken in.
module conv2d_forward_engine import c2d_pkg::*; #(
    parameter int MAX_IN_WIDTH  = DEF_MAX_IN_WIDTH,
    parameter int MAX_IN_HEIGHT = DEF_MAX_IN_HEIGHT,
    parameter int MAX_IN_DEPTH  = DEF_MAX_IN_DEPTH,
    parameter int MAX_SIDE      = DEF_MAX_SIDE,
    parameter int MAX_FILTERS   = DEF_MAX_FILTERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [13:0] addr,
    input  logic [31:0] data,
    input  logic [4:0]  out_col,
    input  logic [4:0]  out_row,
    input  logic [3:0]  filter_sel,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] result,
    output logic        saturated,
    output logic        bad_request
);

    localparam int ACT_DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT * MAX_IN_DEPTH;
    localparam int WGT_DEPTH = MAX_SIDE * MAX_SIDE * MAX_IN_DEPTH * MAX_FILTERS;
    localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int WAW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int BAW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

    logic [5:0] in_width_reg, in_height_reg;
    logic [4:0] in_depth_reg, num_filters_reg;
    logic [2:0] kernel_side_reg, step_reg, padding_reg;

    cfg_t     cfg;
    cmd_t     cmd;
    logic     cmd_valid;
    wr_t      wr;
    bk_stat_t bk;

    logic [AAW-1:0] act_raddr;
    logic [WAW-1:0] wgt_raddr;
    logic [BAW-1:0] bias_raddr;
    logic [15:0]    act_rdata, wgt_rdata;
    logic [31:0]    bias_rdata;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg    <= 6'd1;
            in_height_reg   <= 6'd1;
            in_depth_reg    <= 5'd1;
            kernel_side_reg <= 3'd1;
            step_reg        <= 3'd1;
            padding_reg     <= 3'd0;
            num_filters_reg <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IN_WIDTH:    in_width_reg    <= cfg_data[5:0];
                CFG_IN_HEIGHT:   in_height_reg   <= cfg_data[5:0];
                CFG_IN_DEPTH:    in_depth_reg    <= cfg_data[4:0];
                CFG_KERNEL_SIDE: kernel_side_reg <= cfg_data[2:0];
                CFG_STEP:        step_reg        <= cfg_data[2:0];
                CFG_PADDING:     padding_reg     <= cfg_data[2:0];
                CFG_NUM_FILTERS: num_filters_reg <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // Clamp the geometry to its legal range
    always_comb
    begin
        cfg.w   = (in_width_reg == '0) ? 6'd1 :
                  (32'(in_width_reg) > 32'(MAX_IN_WIDTH)) ? 6'(MAX_IN_WIDTH) : in_width_reg;
        cfg.h   = (in_height_reg == '0) ? 6'd1 :
                  (32'(in_height_reg) > 32'(MAX_IN_HEIGHT)) ? 6'(MAX_IN_HEIGHT)
                                                             : in_height_reg;
        cfg.d   = (in_depth_reg == '0) ? 5'd1 :
                  (32'(in_depth_reg) > 32'(MAX_IN_DEPTH)) ? 5'(MAX_IN_DEPTH) : in_depth_reg;
        cfg.s   = (kernel_side_reg == '0) ? 3'd1 :
                  (32'(kernel_side_reg) > 32'(MAX_SIDE)) ? 3'(MAX_SIDE) : kernel_side_reg;
        cfg.st  = (step_reg == '0) ? 3'd1 : step_reg;
        cfg.pad = padding_reg;
        cfg.nf  = (num_filters_reg == '0) ? 5'd1 :
                  (32'(num_filters_reg) > 32'(MAX_FILTERS)) ? 5'(MAX_FILTERS)
                                                             : num_filters_reg;
    end

    c2d_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
        .clk   (clk),
        .we    (wr.act_we),
        .waddr (AAW'(wr.addr)),
        .wdata (wr.data[15:0]),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    c2d_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt_ram (
        .clk   (clk),
        .we    (wr.wgt_we),
        .waddr (WAW'(wr.addr)),
        .wdata (wr.data[15:0]),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

    c2d_ram #(.WIDTH(32), .DEPTH(MAX_FILTERS)) u_bias_ram (
        .clk   (clk),
        .we    (wr.bias_we),
        .waddr (BAW'(wr.addr)),
        .wdata (wr.data),
        .raddr (bias_raddr),
        .rdata (bias_rdata)
    );

    c2d_front #(
        .ACT_DEPTH   (ACT_DEPTH),
        .WGT_DEPTH   (WGT_DEPTH),
        .MAX_FILTERS (MAX_FILTERS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .addr       (addr),
        .data       (data),
        .out_col    (out_col),
        .out_row    (out_row),
        .filter_sel (filter_sel),
        .cfg        (cfg),
        .bk         (bk),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .wr         (wr)
    );

    c2d_back #(
        .ACT_DEPTH   (ACT_DEPTH),
        .WGT_DEPTH   (WGT_DEPTH),
        .MAX_FILTERS (MAX_FILTERS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .bk          (bk),
        .act_raddr   (act_raddr),
        .act_rdata   (act_rdata),
        .wgt_raddr   (wgt_raddr),
        .wgt_rdata   (wgt_rdata),
        .bias_raddr  (bias_raddr),
        .bias_rdata  (bias_rdata),
        .pop         (pop),
        .empty       (empty),
        .result      (result),
        .saturated   (saturated),
        .bad_request (bad_request)
    );

endmodule

[sv/c2d_checker.sv]
// ---------------------------------------------------------------------------
// c2d_checker: port-level checks of the convolution engine
// Watches the result side for stable items and consistent flags.
// ---------------------------------------------------------------------------
module c2d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] result,
    input logic        saturated,
    input logic        bad_request
);

    // Hold a waiting item until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result) && $stable(saturated)
                              && $stable(bad_request)))
        else $error("waiting result changed before pop");

    // A rejected request carries a zero result and no clamp flag
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bad_request) |-> (result == 32'd0 && !saturated))
        else $error("bad request result not cleared");

    // A clamped result sits at one of the two range limits
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && saturated) |-> (result == 32'h7FFF_FFFF || result == 32'h8000_0000))
        else $error("saturated result not at a limit");

    // Nothing is offered right after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result offered after reset");

endmodule

bind conv2d_forward_engine c2d_checker u_c2d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .saturated   (saturated),
    .bad_request (bad_request)
);
